// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps

package bpa_pkg;

    // heap geometry
    localparam int MAX_ORDER = 10;
    localparam int NUM_PAGES = 1 << MAX_ORDER;
    localparam int PAGE_W    = MAX_ORDER;
    localparam int ORD_W     = 4;
    localparam int SIZE_W    = 20;
    localparam int BYTES_W   = SIZE_W + 1;
    localparam int WORD_LOG  = 5;
    localparam int WORD_BITS = 1 << WORD_LOG;
    localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
    localparam int WADDR_W   = MAX_ORDER - WORD_LOG;

    // request kinds and result codes
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIZE,
        S_SCAN_A,
        S_SCAN_B,
        S_ORD_RD,
        S_ORD_LOAD,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic size_step;
        logic scan_start;
        logic scan_step;
        logic phase_b;
        logic mark_start;
        logic mark_rd;
        logic mark_wr;
        logic ord_rd;
        logic ord_wr;
        logic set_oom;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic req_fit;
        logic req_last;
        logic scan_done;
        logic found;
        logic mark_last;
        logic out_full;
    } t_sts;

endpackage

// ===== rtl/bpa_ram.sv =====
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpa_ctrl.sv =====
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_kind,
    input  bpa_pkg::t_sts i_sts,
    output logic          o_stall,
    output bpa_pkg::t_cmd o_cmd
);

    bpa_pkg::t_state r_state;
    bpa_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            bpa_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_kind == bpa_pkg::KIND_FREE) ? bpa_pkg::S_ORD_RD
                                                             : bpa_pkg::S_SIZE;
                end
            end
            bpa_pkg::S_SIZE: begin
                o_cmd.size_step = 1'b1;
                if (i_sts.req_fit) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = bpa_pkg::S_SCAN_A;
                end else if (i_sts.req_last) begin
                    o_cmd.set_oom = 1'b1;
                    n_state = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_SCAN_A: begin
                if (i_sts.scan_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = bpa_pkg::S_SCAN_B;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            bpa_pkg::S_SCAN_B: begin
                o_cmd.phase_b = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.found) begin
                        o_cmd.mark_start = 1'b1;
                        o_cmd.ord_wr = 1'b1;
                        n_state = bpa_pkg::S_MARK_RD;
                    end else begin
                        o_cmd.set_oom = 1'b1;
                        n_state = bpa_pkg::S_DONE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            bpa_pkg::S_ORD_RD: begin
                o_cmd.ord_rd = 1'b1;
                n_state = bpa_pkg::S_ORD_LOAD;
            end
            bpa_pkg::S_ORD_LOAD: begin
                o_cmd.mark_start = 1'b1;
                n_state = bpa_pkg::S_MARK_RD;
            end
            bpa_pkg::S_MARK_RD: begin
                o_cmd.mark_rd = 1'b1;
                n_state = bpa_pkg::S_MARK_WR;
            end
            bpa_pkg::S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                n_state = i_sts.mark_last ? bpa_pkg::S_DONE : bpa_pkg::S_MARK_RD;
            end
            bpa_pkg::S_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpa_pkg::S_DONE) && !i_sts.out_full |=> (r_state == bpa_pkg::S_IDLE))
        else $error("result slot free but request not retired");
`endif

endmodule

// ===== rtl/bpa_datapath.sv =====
`timescale 1ns / 1ps

module bpa_datapath #(
    parameter int PAGE_BYTES   = 64,
    parameter int HEADER_BYTES = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_kind,
    input  logic [bpa_pkg::SIZE_W-1:0]   i_size_bytes,
    input  logic [bpa_pkg::PAGE_W-1:0]   i_page_index,
    input  logic                         i_stall,
    input  bpa_pkg::t_cmd                i_cmd,
    output bpa_pkg::t_sts                o_sts,
    output logic                         o_valid,
    output logic                         o_status,
    output logic [bpa_pkg::PAGE_W-1:0]   o_start_page,
    output logic [bpa_pkg::ORD_W-1:0]    o_alloc_order
);

    localparam int PW = bpa_pkg::PAGE_W;
    localparam int OW = bpa_pkg::ORD_W;
    localparam int AW = bpa_pkg::WADDR_W;
    localparam int WB = bpa_pkg::WORD_BITS;
    localparam int WL = bpa_pkg::WORD_LOG;
    localparam int MO = bpa_pkg::MAX_ORDER;
    localparam int NW = bpa_pkg::NUM_WORDS;

    // request registers
    logic                          r_kind;
    logic [bpa_pkg::BYTES_W-1:0]   r_bytes;
    logic [PW-1:0]                 r_pidx;
    logic [OW-1:0]                 r_req;
    logic                          r_oom;
    logic [OW-1:0]                 r_free_ord;

    // scan registers
    logic [AW:0]                   r_cnt;
    logic                          r_pend;
    logic [AW-1:0]                 r_paddr;
    logic [NW-1:0]                 r_flags;
    logic [OW-1:0]                 r_best_ord;
    logic [AW-1:0]                 r_best_word;
    logic [WL-1:0]                 r_best_off;

    // bitmap update registers
    logic [PW-1:0]                 r_mark_s;
    logic [PW:0]                   r_mark_e;
    logic                          r_mark_val;
    logic [AW-1:0]                 r_mw;
    logic [NW-1:0]                 r_row_valid;
    logic                          r_rd_row_ok;

    // output slot
    logic                          r_out_valid;
    logic                          r_o_status;
    logic [PW-1:0]                 r_o_start;
    logic [OW-1:0]                 r_o_order;

    logic [31:0]                   w_limit;
    logic                          w_fit;
    logic                          w_issue;
    logic                          w_rd_en;
    logic [AW-1:0]                 w_rd_addr;
    logic [WB-1:0]                 w_ram_rdata;
    logic [WB-1:0]                 w_word;
    logic [WB-1:0]                 w_mask;
    logic [WB-1:0]                 w_wdata;
    logic [OW-1:0]                 w_ord_rdata;
    logic [PW-1:0]                 w_best_page;
    logic [WL:0][WB-1:0]           w_lv;
    logic [WL-1:0][WB-1:0]         w_ex;
    logic [MO:WL][NW-1:0]          w_fl;
    logic [OW-1:0]                 w_wo;
    logic                          w_cand;
    logic [OW-1:0]                 w_cord;
    logic [WL-1:0]                 w_coff;
    logic [AW-1:0]                 w_align;
    logic [16:0]                   w_free_end;
    logic [PW:0]                   w_next_base;

    function automatic logic [WL-1:0] lowest_set(input logic [WB-1:0] v);
        logic [WL-1:0] res;
        res = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = WL'(i);
            end
        end
        return res;
    endfunction

    // size to order search, one order per cycle
    assign w_limit = 32'(PAGE_BYTES) << r_req;
    assign w_fit   = 32'(r_bytes) <= w_limit;

    assign w_best_page = {r_best_word, r_best_off};

    // bitmap read port shared by scan and update
    assign w_issue   = i_cmd.scan_step && !r_cnt[AW];
    assign w_rd_en   = w_issue || i_cmd.mark_rd;
    assign w_rd_addr = i_cmd.mark_rd ? r_mw : r_cnt[AW-1:0];
    assign w_word    = r_rd_row_ok ? w_ram_rdata : '0;

    // free sub-block flags inside one word
    always_comb begin
        w_lv = '0;
        w_lv[0] = ~w_word;
        for (int k = 1; k <= WL; k++) begin
            for (int j = 0; j < (WB >> k); j++) begin
                w_lv[k][j] = w_lv[k-1][2*j] & w_lv[k-1][2*j+1];
            end
        end
        w_ex = '0;
        for (int k = 0; k < WL; k++) begin
            for (int j = 0; j < (WB >> k); j++) begin
                w_ex[k][j] = w_lv[k][j] & ~w_lv[k+1][j>>1];
            end
        end
    end

    // free multi-word blocks from the word flags
    always_comb begin
        w_fl = '0;
        w_fl[WL] = r_flags;
        for (int k = WL + 1; k <= MO; k++) begin
            for (int j = 0; j < (NW >> (k - WL)); j++) begin
                w_fl[k][j] = w_fl[k-1][2*j] & w_fl[k-1][2*j+1];
            end
        end
        w_wo = OW'(WL);
        for (int k = WL + 1; k <= MO; k++) begin
            if (w_fl[k][AW'(r_paddr >> (k - WL))]) begin
                w_wo = OW'(k);
            end
        end
    end

    // best candidate of the current word
    always_comb begin
        w_cand  = 1'b0;
        w_cord  = '0;
        w_coff  = '0;
        w_align = '0;
        if (r_req >= OW'(WL)) begin
            w_align = (AW'(1) << (r_req - OW'(WL))) - AW'(1);
            w_cand  = w_lv[WL][0] && ((r_paddr & w_align) == '0) && (w_wo >= r_req);
            w_cord  = w_wo;
        end else if (w_lv[WL][0]) begin
            w_cand = 1'b1;
            w_cord = w_wo;
        end else begin
            for (int k = WL - 1; k >= 0; k--) begin
                if ((OW'(k) >= r_req) && (|w_ex[k])) begin
                    w_cand = 1'b1;
                    w_cord = OW'(k);
                    w_coff = WL'(lowest_set(w_ex[k]) << k);
                end
            end
        end
    end

    // page mask and new word for the update pass
    always_comb begin
        for (int b = 0; b < WB; b++) begin
            w_mask[b] = ({1'b0, r_mw, WL'(b)} >= {1'b0, r_mark_s}) &&
                        ({1'b0, r_mw, WL'(b)} < r_mark_e);
        end
        w_wdata = r_mark_val ? (w_word | w_mask) : (w_word & ~w_mask);
    end

    assign w_free_end  = 17'(r_pidx) + (17'(1) << w_ord_rdata);
    assign w_next_base = {1'b0, r_mw, WL'(0)} + (PW+1)'(WB);

    // request, scan and update registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_bytes <= bpa_pkg::BYTES_W'(i_size_bytes) + bpa_pkg::BYTES_W'(HEADER_BYTES);
            r_pidx  <= i_page_index;
            r_req   <= '0;
        end else if (i_cmd.size_step && !w_fit) begin
            r_req <= r_req + OW'(1);
        end
        if (i_cmd.scan_step && r_pend && !i_cmd.phase_b) begin
            r_flags[r_paddr] <= (w_word == '0);
        end
        if (i_cmd.scan_step && r_pend && i_cmd.phase_b && w_cand && (w_cord < r_best_ord)) begin
            r_best_word <= r_paddr;
            r_best_off  <= w_coff;
        end
        if (w_rd_en) begin
            r_rd_row_ok <= r_row_valid[w_rd_addr];
        end
        if (i_cmd.mark_start) begin
            if (r_kind == bpa_pkg::KIND_ALLOC) begin
                r_mark_s   <= w_best_page;
                r_mark_e   <= {1'b0, w_best_page} + ((PW+1)'(1) << r_req);
                r_mark_val <= 1'b1;
                r_mw       <= w_best_page[PW-1:WL];
            end else begin
                r_mark_s   <= r_pidx;
                r_mark_e   <= (w_free_end > 17'(bpa_pkg::NUM_PAGES))
                              ? (PW+1)'(bpa_pkg::NUM_PAGES) : w_free_end[PW:0];
                r_mark_val <= 1'b0;
                r_mw       <= r_pidx[PW-1:WL];
                r_free_ord <= w_ord_rdata;
            end
        end else if (i_cmd.mark_wr) begin
            r_mw <= r_mw + AW'(1);
        end
        if (i_cmd.out_load) begin
            if (r_oom) begin
                r_o_status <= bpa_pkg::STATUS_OOM;
                r_o_start  <= '0;
                r_o_order  <= '0;
            end else if (r_kind == bpa_pkg::KIND_ALLOC) begin
                r_o_status <= bpa_pkg::STATUS_OK;
                r_o_start  <= w_best_page;
                r_o_order  <= r_req;
            end else begin
                r_o_status <= bpa_pkg::STATUS_OK;
                r_o_start  <= r_pidx;
                r_o_order  <= r_free_ord;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oom       <= 1'b0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_best_ord  <= OW'(MO + 1);
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_oom      <= 1'b0;
                r_best_ord <= OW'(MO + 1);
            end else if (i_cmd.set_oom) begin
                r_oom <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend  <= w_issue;
                if (w_issue) begin
                    r_cnt <= r_cnt + (AW+1)'(1);
                end
            end
            if (i_cmd.scan_step && r_pend && i_cmd.phase_b && w_cand && (w_cord < r_best_ord)) begin
                r_best_ord <= w_cord;
            end
            if (i_cmd.mark_wr) begin
                r_row_valid[r_mw] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan progress register for the read pipeline address
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_paddr <= r_cnt[AW-1:0];
        end
    end

    // page-used bitmap, one word of pages per row
    bpa_ram #(
        .WIDTH (WB),
        .DEPTH (NW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mark_wr),
        .i_waddr (r_mw),
        .i_wdata (w_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    // block order kept at the first page of each block
    bpa_ram #(
        .WIDTH (OW),
        .DEPTH (bpa_pkg::NUM_PAGES)
    ) u_orders (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ord_wr),
        .i_waddr (w_best_page),
        .i_wdata (r_req),
        .i_re    (i_cmd.ord_rd),
        .i_raddr (r_pidx),
        .o_rdata (w_ord_rdata)
    );

    // status to the controller
    always_comb begin
        o_sts.req_fit   = w_fit;
        o_sts.req_last  = (r_req == OW'(MO));
        o_sts.scan_done = r_cnt[AW] && !r_pend;
        o_sts.found     = (r_best_ord <= OW'(MO));
        o_sts.mark_last = (w_next_base >= r_mark_e);
        o_sts.out_full  = r_out_valid && i_stall;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_start_page  = r_o_start;
    assign o_alloc_order = r_o_order;

`ifndef NO_ASSERTIONS
    a_best_not_below_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_ord <= OW'(MO)) |-> (r_best_ord >= r_req))
        else $error("chosen block smaller than requested order");
    a_clear_only_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_wr && !r_mark_val |-> (r_kind == bpa_pkg::KIND_FREE))
        else $error("pages cleared during an allocate");
    a_update_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_wr |-> ({1'b0, r_mw, WL'(0)} < r_mark_e))
        else $error("bitmap row written past the end of the block");
`endif

endmodule

// ===== rtl/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
// allocate: order search, two bitmap sweeps, a read and a write per 32-page row marked, then
//   the result load; oversize ends after the search, no fit after the sweeps
// free: order read, order load, a read and a write per 32-page bitmap row cleared, result load
// throughput: one request at a time, set by the bitmap row sweeps on its one read port; a finished
//   result waits in an output register while the next request is taken
// reset: synchronous, active low; every page free at once through per-row valid flags
module buddy_page_allocator #(
    parameter int PAGE_BYTES   = 64,
    parameter int HEADER_BYTES = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_kind,
    input  logic [bpa_pkg::SIZE_W-1:0]   i_size_bytes,
    input  logic [bpa_pkg::PAGE_W-1:0]   i_page_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_status,
    output logic [bpa_pkg::PAGE_W-1:0]   o_start_page,
    output logic [bpa_pkg::ORD_W-1:0]    o_alloc_order
);

    bpa_pkg::t_cmd w_cmd;
    bpa_pkg::t_sts w_sts;

    // sequencer
    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    // bitmap, order store and scan logic
    bpa_datapath #(
        .PAGE_BYTES   (PAGE_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kind        (i_kind),
        .i_size_bytes  (i_size_bytes),
        .i_page_index  (i_page_index),
        .i_stall       (i_stall),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_start_page  (o_start_page),
        .o_alloc_order (o_alloc_order)
    );

endmodule
